/* rtl/lbdo_pkg.sv */
// Shared constants, types and helper functions for the LIFO drop-oldest request buffer.
package lbdo_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SLOT_W  = 4;
    localparam int SRC_W   = 8;
    localparam int REQ_W   = 16;
    localparam int TIME_W  = 32;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [SRC_W-1:0]  source;
        logic [REQ_W-1:0]  request;
        logic [TIME_W-1:0] arr_time;
    } entry_t;

    typedef struct packed {
        logic   en;
        idx_t   addr;
        entry_t data;
    } ram_wr_t;

    typedef enum logic [1:0] {
        STATUS_STORED  = 2'd0,
        STATUS_EVICTED = 2'd1,
        STATUS_TAKEN   = 2'd2,
        STATUS_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FREE,
        S_SCAN,
        S_FIN
    } state_t;

    localparam logic MODE_STORE = 1'b0;
    localparam logic MODE_TAKE  = 1'b1;

    // Advance a slot index around the ring.
    function automatic idx_t next_idx(input idx_t i);
        idx_t r;
        if (i == idx_t'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = i + idx_t'(1);
        end
        return r;
    endfunction

    // Wait time, clamped at zero when the arrival lies in the future.
    function automatic logic [TIME_W-1:0] wait_of(input logic [TIME_W-1:0] now_t,
                                                   input logic [TIME_W-1:0] then_t);
        logic [TIME_W-1:0] r;
        if (now_t >= then_t) begin
            r = now_t - then_t;
        end else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

/* rtl/lbdo_slot_ram.sv */
// Slot payload memory: one write port, one read port with registered read data.
module lbdo_slot_ram (
    input  logic              aclk,
    input  lbdo_pkg::ram_wr_t wr,
    input  logic              rd_en,
    input  lbdo_pkg::idx_t    rd_addr,
    output lbdo_pkg::entry_t  rd_data
);

    lbdo_pkg::entry_t mem [lbdo_pkg::DEPTH];
    lbdo_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/lifo_buffer_drop_oldest.sv */
// Top level of the LIFO request buffer with drop-oldest overflow.
//
// The block keeps DEPTH request slots (source, request number, arrival time)
// in a single-port-read synchronous memory, with the occupancy bits and the
// ring write pointer in flip-flops. One transaction is worked at a time. A
// store that finds a free slot walks the occupancy bits from the write
// pointer, one slot per cycle, to the first free slot. A store into a full
// buffer and every take read all DEPTH slots through the memory's one read
// port, one per cycle; that read port sets the rate. The result sits in an
// output register, so the next transaction is accepted while it waits to
// be taken; the block only stalls finishing a transaction while that
// register is still full. Ties in the oldest and newest searches go to the
// lowest slot.
module lifo_buffer_drop_oldest (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_mode,
    input  logic [lbdo_pkg::TIME_W-1:0] s_now_time,
    input  logic [lbdo_pkg::SRC_W-1:0]  s_source_id,
    input  logic [lbdo_pkg::REQ_W-1:0]  s_request_number,
    input  logic [lbdo_pkg::TIME_W-1:0] s_arrival_time,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [lbdo_pkg::SLOT_W-1:0] m_slot,
    output logic [lbdo_pkg::SRC_W-1:0]  m_out_source,
    output logic [lbdo_pkg::REQ_W-1:0]  m_out_request,
    output logic [lbdo_pkg::TIME_W-1:0] m_out_wait,
    output logic                        m_empty_after
);

    // control state
    lbdo_pkg::state_t            state_reg, state_next;
    logic [lbdo_pkg::DEPTH-1:0]  valid_reg, valid_next;
    lbdo_pkg::idx_t              wp_reg, wp_next;
    logic [lbdo_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        rd_vld_reg, rd_vld_next;
    logic                        found_reg, found_next;
    logic                        m_valid_reg, m_valid_next;

    // payload state
    logic                        mode_reg;
    logic [lbdo_pkg::TIME_W-1:0] now_reg;
    lbdo_pkg::entry_t            new_reg;
    lbdo_pkg::idx_t              idx_reg, idx_next;
    lbdo_pkg::idx_t              rd_idx_reg, rd_idx_next;
    lbdo_pkg::entry_t            best_reg, best_next;
    logic [1:0]                  status_reg, status_next;
    logic [lbdo_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [lbdo_pkg::SRC_W-1:0]  osrc_reg, osrc_next;
    logic [lbdo_pkg::REQ_W-1:0]  oreq_reg, oreq_next;
    logic [lbdo_pkg::TIME_W-1:0] owait_reg, owait_next;
    logic                        oempty_reg, oempty_next;

    // memory ports
    lbdo_pkg::ram_wr_t           ram_wr;
    logic                        ram_rd_en;
    lbdo_pkg::idx_t              ram_rd_addr;
    lbdo_pkg::entry_t            ram_rd_data;

    logic                        accept;
    logic                        out_free;
    logic                        load_out;
    logic                        cand;
    logic                        better;

    lbdo_slot_ram u_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_ready  = (state_reg == lbdo_pkg::S_IDLE);
    assign accept   = s_valid && s_ready;
    // the output register can take a new result this cycle
    assign out_free = !m_valid_reg || m_ready;

    // candidate test on the entry returned by the memory this cycle
    always_comb begin
        if (mode_reg == lbdo_pkg::MODE_TAKE) begin
            cand   = valid_reg[rd_idx_reg];
            better = ram_rd_data.arr_time > best_reg.arr_time;
        end else begin
            cand   = 1'b1;
            better = ram_rd_data.arr_time < best_reg.arr_time;
        end
    end

    always_comb begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        wp_next      = wp_reg;
        cnt_next     = cnt_reg;
        rd_vld_next  = 1'b0;
        found_next   = found_reg;
        idx_next     = idx_reg;
        rd_idx_next  = rd_idx_reg;
        best_next    = best_reg;
        status_next  = status_reg;
        slot_next    = slot_reg;
        osrc_next    = osrc_reg;
        oreq_next    = oreq_reg;
        owait_next   = owait_reg;
        oempty_next  = oempty_reg;
        load_out     = 1'b0;
        ram_wr       = '0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = cnt_reg[lbdo_pkg::IDX_W-1:0];

        case (state_reg)
            lbdo_pkg::S_IDLE: begin
                if (accept) begin
                    idx_next   = wp_reg;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    // a store into a buffer with room only needs the occupancy bits
                    if (s_mode == lbdo_pkg::MODE_STORE && !(&valid_reg)) begin
                        state_next = lbdo_pkg::S_FREE;
                    end else begin
                        state_next = lbdo_pkg::S_SCAN;
                    end
                end
            end

            lbdo_pkg::S_FREE: begin
                // walk the ring from the write pointer to the first free slot
                if (valid_reg[idx_reg]) begin
                    idx_next = lbdo_pkg::next_idx(idx_reg);
                end else if (out_free) begin
                    ram_wr.en             = 1'b1;
                    ram_wr.addr           = idx_reg;
                    ram_wr.data           = new_reg;
                    valid_next[idx_reg]   = 1'b1;
                    wp_next               = lbdo_pkg::next_idx(idx_reg);
                    status_next           = lbdo_pkg::STATUS_STORED;
                    slot_next             = lbdo_pkg::SLOT_W'(idx_reg);
                    osrc_next             = '0;
                    oreq_next             = '0;
                    owait_next            = '0;
                    oempty_next           = 1'b0;
                    load_out              = 1'b1;
                    state_next            = lbdo_pkg::S_IDLE;
                end
            end

            lbdo_pkg::S_SCAN: begin
                // issue one read per cycle, compare the entry that comes back
                if (cnt_reg < lbdo_pkg::CNT_W'(lbdo_pkg::DEPTH)) begin
                    ram_rd_en   = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = cnt_reg[lbdo_pkg::IDX_W-1:0];
                    cnt_next    = cnt_reg + lbdo_pkg::CNT_W'(1);
                end
                if (rd_vld_reg && cand && (!found_reg || better)) begin
                    found_next = 1'b1;
                    idx_next   = rd_idx_reg;
                    best_next  = ram_rd_data;
                end
                if (!rd_vld_reg && cnt_reg == lbdo_pkg::CNT_W'(lbdo_pkg::DEPTH)) begin
                    state_next = lbdo_pkg::S_FIN;
                end
            end

            lbdo_pkg::S_FIN: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = lbdo_pkg::S_IDLE;
                    if (mode_reg == lbdo_pkg::MODE_STORE) begin
                        // full: drop the oldest and reuse its slot
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = idx_reg;
                        ram_wr.data = new_reg;
                        wp_next     = lbdo_pkg::next_idx(idx_reg);
                        status_next = lbdo_pkg::STATUS_EVICTED;
                        slot_next   = lbdo_pkg::SLOT_W'(idx_reg);
                        osrc_next   = best_reg.source;
                        oreq_next   = best_reg.request;
                        owait_next  = lbdo_pkg::wait_of(now_reg, best_reg.arr_time);
                        oempty_next = 1'b0;
                    end else if (found_reg) begin
                        valid_next[idx_reg] = 1'b0;
                        status_next = lbdo_pkg::STATUS_TAKEN;
                        slot_next   = lbdo_pkg::SLOT_W'(idx_reg);
                        osrc_next   = best_reg.source;
                        oreq_next   = best_reg.request;
                        owait_next  = lbdo_pkg::wait_of(now_reg, best_reg.arr_time);
                        oempty_next = ~|valid_next;
                    end else begin
                        status_next = lbdo_pkg::STATUS_EMPTY;
                        slot_next   = '0;
                        osrc_next   = '0;
                        oreq_next   = '0;
                        owait_next  = '0;
                        oempty_next = 1'b1;
                    end
                end
            end

            default: begin
                state_next = lbdo_pkg::S_IDLE;
            end
        endcase

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lbdo_pkg::S_IDLE;
            valid_reg   <= '0;
            wp_reg      <= '0;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            wp_reg      <= wp_next;
            cnt_reg     <= cnt_next;
            rd_vld_reg  <= rd_vld_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg         <= s_mode;
            now_reg          <= s_now_time;
            new_reg.source   <= s_source_id;
            new_reg.request  <= s_request_number;
            new_reg.arr_time <= s_arrival_time;
        end
        idx_reg    <= idx_next;
        rd_idx_reg <= rd_idx_next;
        best_reg   <= best_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        osrc_reg   <= osrc_next;
        oreq_reg   <= oreq_next;
        owait_reg  <= owait_next;
        oempty_reg <= oempty_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_slot        = slot_reg;
    assign m_out_source  = osrc_reg;
    assign m_out_request = oreq_reg;
    assign m_out_wait    = owait_reg;
    assign m_empty_after = oempty_reg;

    // a store always leaves at least one occupied slot
    a_store_occupies: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out && (status_next == lbdo_pkg::STATUS_STORED ||
                     status_next == lbdo_pkg::STATUS_EVICTED)
        |=> (valid_reg != '0) && !m_empty_after)
        else $error("store finished with no occupied slot");

    // a take on an empty buffer reports nothing and an empty buffer
    a_take_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == lbdo_pkg::STATUS_EMPTY
        |-> m_slot == '0 && m_out_wait == '0 && m_empty_after && valid_reg == '0)
        else $error("take on empty reported stale data");

    // the slot memory is written only when a transaction completes
    a_write_at_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr.en |-> (state_reg == lbdo_pkg::S_FREE || state_reg == lbdo_pkg::S_FIN)
                      && out_free)
        else $error("slot memory written outside completion");

    // the write pointer stays inside the ring
    a_wp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, wp_reg} < (lbdo_pkg::IDX_W + 1)'(lbdo_pkg::DEPTH))
        else $error("write pointer out of range");

endmodule

/* bench/tb_lifo_buffer_drop_oldest.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the LIFO request buffer with drop-oldest overflow.
module tb_lifo_buffer_drop_oldest;

    localparam int HALF_PERIOD  = 4;
    // Worst case: a full scan of every slot plus the output register.
    localparam int DRAIN_CYCLES = lbdo_pkg::DEPTH + 4;
    localparam int LONG_HOLD    = 250;
    localparam int BLOCK_ITEMS  = 30;
    localparam int RANDOM_ITEMS = 390;
    localparam int MAX_REPORTS  = 10;

    // One request as it crosses the input channel.
    typedef struct packed {
        logic                        mode;
        logic [lbdo_pkg::TIME_W-1:0] now_ticks;
        logic [lbdo_pkg::SRC_W-1:0]  source;
        logic [lbdo_pkg::REQ_W-1:0]  number;
        logic [lbdo_pkg::TIME_W-1:0] arrival;
    } request_t;

    // One answer as it crosses the result channel.
    typedef struct packed {
        lbdo_pkg::status_t           status;
        logic [lbdo_pkg::SLOT_W-1:0] slot;
        logic [lbdo_pkg::SRC_W-1:0]  source;
        logic [lbdo_pkg::REQ_W-1:0]  number;
        logic [lbdo_pkg::TIME_W-1:0] wait_ticks;
        logic                        empty;
    } outcome_t;

    logic                        aclk             = 1'b0;
    logic                        aresetn          = 1'b0;
    logic                        s_valid          = 1'b0;
    logic                        s_ready;
    logic                        s_mode           = 1'b0;
    logic [lbdo_pkg::TIME_W-1:0] s_now_time       = '0;
    logic [lbdo_pkg::SRC_W-1:0]  s_source_id      = '0;
    logic [lbdo_pkg::REQ_W-1:0]  s_request_number = '0;
    logic [lbdo_pkg::TIME_W-1:0] s_arrival_time   = '0;
    logic                        m_valid;
    logic                        m_ready          = 1'b0;
    logic [1:0]                  m_status;
    logic [lbdo_pkg::SLOT_W-1:0] m_slot;
    logic [lbdo_pkg::SRC_W-1:0]  m_out_source;
    logic [lbdo_pkg::REQ_W-1:0]  m_out_request;
    logic [lbdo_pkg::TIME_W-1:0] m_out_wait;
    logic                        m_empty_after;

    lifo_buffer_drop_oldest dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_now_time       (s_now_time),
        .s_source_id      (s_source_id),
        .s_request_number (s_request_number),
        .s_arrival_time   (s_arrival_time),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_slot           (m_slot),
        .m_out_source     (m_out_source),
        .m_out_request    (m_out_request),
        .m_out_wait       (m_out_wait),
        .m_empty_after    (m_empty_after)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Shadow copy of the slot store, kept in step with accepted transactions.
    logic                        occupied     [lbdo_pkg::DEPTH];
    logic [lbdo_pkg::SRC_W-1:0]  held_source  [lbdo_pkg::DEPTH];
    logic [lbdo_pkg::REQ_W-1:0]  held_number  [lbdo_pkg::DEPTH];
    logic [lbdo_pkg::TIME_W-1:0] held_arrival [lbdo_pkg::DEPTH];
    int                          ring_ptr;

    request_t pending_requests[$];    // waiting to be offered
    outcome_t expected_outcomes[$];   // accepted, answer not yet seen

    int mismatches    = 0;
    int results_seen  = 0;
    int status_count[4];
    int hold_requests = 0;
    int holds_done    = 0;

    // Sender state: set at the falling edge, handshake flag from the rising edge.
    logic offer_taken = 1'b0;
    int   burst_left  = 0;
    int   gap_left    = 0;

    // Receiver state.
    int hold_left    = 0;
    int style_left   = 0;
    int ready_style  = 0;

    logic [lbdo_pkg::TIME_W-1:0] clock_now;

    // Apply one transaction to the shadow store and return the answer it earns.
    // Store: first free slot from the ring pointer, else evict the oldest
    // arrival (lowest slot on ties). Take: newest arrival, lowest slot on ties.
    function automatic outcome_t serve_request(input request_t rq);
        outcome_t res;
        int       pick;
        int       idx;
        int       k;
        bit       found;
        bit       report;
        res    = '0;
        pick   = 0;
        found  = 1'b0;
        report = 1'b0;
        if (rq.mode == lbdo_pkg::MODE_STORE) begin
            res.status = lbdo_pkg::STATUS_STORED;
            for (k = 0; k < lbdo_pkg::DEPTH; k++) begin
                idx = (ring_ptr + k) % lbdo_pkg::DEPTH;
                if (!found && !occupied[idx]) begin
                    pick  = idx;
                    found = 1'b1;
                end
            end
            if (!found) begin
                for (idx = 1; idx < lbdo_pkg::DEPTH; idx++) begin
                    if (held_arrival[idx] < held_arrival[pick]) begin
                        pick = idx;
                    end
                end
                res.status = lbdo_pkg::STATUS_EVICTED;
                report     = 1'b1;
            end
        end else begin
            for (idx = 0; idx < lbdo_pkg::DEPTH; idx++) begin
                if (occupied[idx] && (!found || held_arrival[idx] > held_arrival[pick])) begin
                    pick  = idx;
                    found = 1'b1;
                end
            end
            res.status = found ? lbdo_pkg::STATUS_TAKEN : lbdo_pkg::STATUS_EMPTY;
            report     = found;
        end

        // Report the displaced or served entry before the store changes.
        if (report) begin
            res.source     = held_source[pick];
            res.number     = held_number[pick];
            res.wait_ticks = (rq.now_ticks >= held_arrival[pick]) ?
                             rq.now_ticks - held_arrival[pick] : '0;
        end
        res.slot = pick[lbdo_pkg::SLOT_W-1:0];

        if (rq.mode == lbdo_pkg::MODE_STORE) begin
            occupied[pick]     = 1'b1;
            held_source[pick]  = rq.source;
            held_number[pick]  = rq.number;
            held_arrival[pick] = rq.arrival;
            ring_ptr           = (pick + 1) % lbdo_pkg::DEPTH;
        end else if (found) begin
            occupied[pick] = 1'b0;
        end

        res.empty = 1'b1;
        for (idx = 0; idx < lbdo_pkg::DEPTH; idx++) begin
            if (occupied[idx]) begin
                res.empty = 1'b0;
            end
        end
        return res;
    endfunction

    task automatic queue_request(input logic mode,
                                 input logic [lbdo_pkg::TIME_W-1:0] now_ticks,
                                 input logic [lbdo_pkg::SRC_W-1:0] source,
                                 input logic [lbdo_pkg::REQ_W-1:0] number,
                                 input logic [lbdo_pkg::TIME_W-1:0] arrival);
        request_t rq;
        rq.mode      = mode;
        rq.now_ticks = now_ticks;
        rq.source    = source;
        rq.number    = number;
        rq.arrival   = arrival;
        pending_requests = {pending_requests, rq};
    endtask

    // Random request. Time mostly moves forward, with a few wild values, arrivals
    // in the future, and arrivals clustered on a common base so ties come up.
    task automatic queue_random(input int take_pct);
        request_t                    rq;
        int                          flavor;
        logic [lbdo_pkg::TIME_W-1:0] tie_base;
        clock_now    = clock_now + lbdo_pkg::TIME_W'($urandom_range(0, 40));
        tie_base     = clock_now & 32'hFFFF_FF00;
        rq.mode      = ($urandom_range(0, 99) < take_pct) ? lbdo_pkg::MODE_TAKE
                                                          : lbdo_pkg::MODE_STORE;
        rq.now_ticks = ($urandom_range(0, 9) == 0) ? lbdo_pkg::TIME_W'($urandom)
                                                   : clock_now;
        rq.source    = lbdo_pkg::SRC_W'($urandom);
        rq.number    = lbdo_pkg::REQ_W'($urandom);
        flavor       = $urandom_range(0, 9);
        case (flavor)
            0: begin
                rq.arrival = lbdo_pkg::TIME_W'($urandom);
            end
            1: begin
                rq.arrival = rq.now_ticks + lbdo_pkg::TIME_W'($urandom_range(1, 100));
            end
            2, 3: begin
                rq.arrival = tie_base + lbdo_pkg::TIME_W'($urandom_range(0, 2));
            end
            default: begin
                rq.arrival = rq.now_ticks - lbdo_pkg::TIME_W'($urandom_range(0, 300));
            end
        endcase
        pending_requests = {pending_requests, rq};
    endtask

    // Hold the sender until everything queued is accepted and answered.
    task automatic drain_results();
        while (pending_requests.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (expected_outcomes.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Driver: change inputs at the falling edge only. Once valid is up it holds
    // with the same payload until the rising edge records the handshake.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || offer_taken) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                request_t rq;
                rq = pending_requests.pop_front();
                s_mode           <= rq.mode;
                s_now_time       <= rq.now_ticks;
                s_source_id      <= rq.source;
                s_request_number <= rq.number;
                s_arrival_time   <= rq.arrival;
                s_valid          <= 1'b1;
                // Bursts of back-to-back offers, then a gap; a zero gap
                // leaves long stretches with no idling at all.
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: a long hold-off on request, otherwise a rotating stall style:
    // always ready, coin flip, or mostly stalled.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (holds_done != hold_requests) begin
                holds_done = holds_done + 1;
                hold_left  = LONG_HOLD;
            end
            if (style_left == 0) begin
                style_left  = $urandom_range(16, 80);
                ready_style = $urandom_range(0, 2);
            end else begin
                style_left = style_left - 1;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                case (ready_style)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Monitor: at the rising edge, check an answer leaving first, then predict
    // the transaction entering. An answer always trails its own request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            offer_taken <= 1'b0;
        end else begin
            offer_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                outcome_t got;
                outcome_t want;
                got.status     = lbdo_pkg::status_t'(m_status);
                got.slot       = m_slot;
                got.source     = m_out_source;
                got.number     = m_out_request;
                got.wait_ticks = m_out_wait;
                got.empty      = m_empty_after;
                results_seen   = results_seen + 1;
                if (expected_outcomes.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: unexpected result status %0d slot %0d", $time,
                                 m_status, m_slot);
                    end
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got.status != want.status || got.slot != want.slot ||
                        got.source != want.source || got.number != want.number ||
                        got.wait_ticks != want.wait_ticks || got.empty != want.empty) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: result %0d mismatch", $time, results_seen);
                            $display("  expected status %0d slot %0d src %h req %h wait %h empty %b",
                                     want.status, want.slot, want.source, want.number,
                                     want.wait_ticks, want.empty);
                            $display("  actual   status %0d slot %0d src %h req %h wait %h empty %b",
                                     got.status, got.slot, got.source, got.number,
                                     got.wait_ticks, got.empty);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                request_t rq;
                outcome_t res;
                rq.mode      = s_mode;
                rq.now_ticks = s_now_time;
                rq.source    = s_source_id;
                rq.number    = s_request_number;
                rq.arrival   = s_arrival_time;
                res = serve_request(rq);
                status_count[res.status] = status_count[res.status] + 1;
                expected_outcomes = {expected_outcomes, res};
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int blk;
        int take_pct;
        foreach (occupied[i]) begin
            occupied[i] = 1'b0;
        end
        foreach (status_count[i]) begin
            status_count[i] = 0;
        end
        ring_ptr  = 0;
        clock_now = lbdo_pkg::TIME_W'($urandom);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: take on an empty buffer, field extremes, arrival later than
        // now, then fill every slot with tied arrival times so the eviction
        // and the newest take both have to break ties on the lowest slot, and
        // a final store whose free-slot search wraps past the top.
        queue_request(lbdo_pkg::MODE_TAKE, 32'd5, '0, '0, '0);
        queue_request(lbdo_pkg::MODE_STORE, 32'd0, 8'h00, 16'h0000, 32'h0000_0000);
        queue_request(lbdo_pkg::MODE_STORE, 32'd0, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_request(lbdo_pkg::MODE_TAKE, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_request(lbdo_pkg::MODE_TAKE, 32'd10, '0, '0, '0);
        queue_request(lbdo_pkg::MODE_TAKE, 32'd0, '0, '0, '0);
        for (int i = 0; i < lbdo_pkg::DEPTH; i++) begin
            queue_request(lbdo_pkg::MODE_STORE, 32'd200, lbdo_pkg::SRC_W'(i * 17),
                          lbdo_pkg::REQ_W'(16'hA5A5 ^ i), lbdo_pkg::TIME_W'(100 + i % 4));
        end
        queue_request(lbdo_pkg::MODE_STORE, 32'd40, 8'h5A, 16'h1234, 32'd50);
        queue_request(lbdo_pkg::MODE_TAKE, 32'hFFFF_FFFF, '0, '0, '0);
        queue_request(lbdo_pkg::MODE_STORE, 32'd300, 8'hC3, 16'h8001, 32'd290);
        drain_results();

        // Back-pressure: stall the receiver for a long stretch while the sender
        // keeps offering, so the output register fills and the input stalls.
        hold_requests = hold_requests + 1;
        repeat (40) queue_random(30);
        drain_results();

        // Random: alternate store-heavy blocks (fill and evict), take-heavy
        // blocks (drain and hit empty) and balanced ones; pause the sender
        // until the block is quiet every few blocks.
        for (blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
            case (blk % 3)
                0:       take_pct = 20;
                1:       take_pct = 75;
                default: take_pct = 45;
            endcase
            repeat (BLOCK_ITEMS) queue_random(take_pct);
            if (blk % 5 == 4) begin
                drain_results();
            end
        end
        drain_results();

        // Let any stray result surface before closing out.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_outcomes.size() != 0) begin
            mismatches = mismatches + expected_outcomes.size();
            $display("%0d expected results never arrived", expected_outcomes.size());
        end

        $display("covered %0d results: %0d plain stores, %0d evicting stores, %0d takes,",
                 results_seen, status_count[lbdo_pkg::STATUS_STORED],
                 status_count[lbdo_pkg::STATUS_EVICTED],
                 status_count[lbdo_pkg::STATUS_TAKEN]);
        $display("  %0d takes on an empty buffer, %0d mismatches",
                 status_count[lbdo_pkg::STATUS_EMPTY], mismatches);
        if (mismatches == 0) begin
            $display("lifo_buffer_drop_oldest regression: pass");
        end else begin
            $display("lifo_buffer_drop_oldest regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(5_000_000);
        $display("timeout waiting for results");
        $display("lifo_buffer_drop_oldest regression: fail");
        $finish;
    end

endmodule
